// ----- hw/rtl/fbm_gradient_noise_2d_macros.svh -----
// Assertion macros shared by the terrain noise RTL.
`ifndef FBM_GRADIENT_NOISE_2D_MACROS_SVH
`define FBM_GRADIENT_NOISE_2D_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define FGN_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define FGN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fgn_pkg.sv -----
// Shared types, widths, constants and the angle table builder for the noise pipeline.
package fgn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int ANGLE_BITS_DEF  = 10;

    localparam int P_W    = 64;
    localparam int AMP_W  = 37;
    localparam int TOT_W  = 61;
    localparam int TAMP_W = 41;
    localparam int Q_W    = 20;
    localparam int NZ_W   = 19;
    localparam int CS_W   = 17;
    localparam int D_W    = 18;
    localparam int G_W    = 36;
    localparam int L_W    = 38;
    localparam int U_W    = 17;
    localparam int F_W    = 16;
    localparam int PR_W   = L_W + U_W + 1;

    localparam logic [AMP_W-1:0] AMP_ONE = 37'd65536;
    localparam logic [AMP_W-1:0] AMP_CAP = 37'h0F_FFFF_FFFF;

    localparam logic [31:0] HASH_CX = 32'h8da6b343;
    localparam logic [31:0] HASH_CZ = 32'hd8163841;
    localparam logic [31:0] MIX_A   = 32'h7feb352d;
    localparam logic [31:0] MIX_B   = 32'h846ca68b;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] REG_SEED  = 3'd0;
    localparam logic [CFG_W-1:0] REG_OCTS  = 3'd1;
    localparam logic [CFG_W-1:0] REG_BFREQ = 3'd2;
    localparam logic [CFG_W-1:0] REG_LAC   = 3'd3;
    localparam logic [CFG_W-1:0] REG_GAIN  = 3'd4;
    localparam logic [CFG_W-1:0] REG_SCALE = 3'd5;

    localparam logic [31:0] SEED_RST  = 32'd0;
    localparam logic [3:0]  OCTS_RST  = 4'd4;
    localparam logic [31:0] BFREQ_RST = 32'd16777216;
    localparam logic [23:0] LAC_RST   = 24'd131072;
    localparam logic [19:0] GAIN_RST  = 20'd32768;
    localparam logic [23:0] SCALE_RST = 24'd65536;

    typedef struct packed {
        logic                     v;
        logic [P_W-1:0]           px;
        logic [P_W-1:0]           pz;
        logic [AMP_W-1:0]         amp;
        logic signed [TOT_W-1:0]  tot;
        logic [TAMP_W-1:0]        tamp;
    } oct_bus_t;

    typedef struct packed {
        logic              v;
        logic [TAMP_W-1:0] rem;
        logic [TAMP_W-1:0] den;
        logic [Q_W-1:0]    low;
        logic [Q_W-1:0]    quo;
        logic              neg;
    } div_bus_t;

    // Sine in the upper half, cosine in the lower half, both Q1.15 rounded,
    // for quarter-wave step m; evaluated at elaboration only.
    function automatic logic [31:0] cs_entry(input int unsigned m, input int unsigned qb);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] sq;
        logic [63:0] sv;
        logic [63:0] cv;
        a  = (64'(m) * HALF_PI_Q30) >> qb;
        a2 = (a * a) >> 30;
        t  = ONE_Q30 - a2 / 64'd72;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd6;
        sq = (a * t) >> 30;
        t  = ONE_Q30 - a2 / 64'd56;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd30;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd12;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd2;
        sv = (sq + 64'd16384) >> 15;
        cv = (t + 64'd16384) >> 15;
        return {sv[15:0], cv[15:0]};
    endfunction

endpackage

// ----- hw/rtl/fgn_octave_cell.sv -----
// One octave of gradient noise as a twelve-stage pipeline cell of the octave chain.
module fgn_octave_cell #(
    parameter int ANGLE_BITS = fgn_pkg::ANGLE_BITS_DEF,
    parameter int OCT_IDX    = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             octave_on,
    input  logic [31:0]      seed,
    input  logic [23:0]      lac,
    input  logic [19:0]      gain,
    input  fgn_pkg::oct_bus_t bus_in,
    output fgn_pkg::oct_bus_t bus_out
);

    localparam int QB  = ANGLE_BITS - 2;
    localparam int QN  = 1 << (QB - 1);
    localparam int NST = 12;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef logic [31:0] cs_rom_t [QN+1];

    function automatic cs_rom_t build_rom();
        cs_rom_t rom;
        for (int i = 0; i <= QN; i++)
        begin
            rom[i] = fgn_pkg::cs_entry(i, QB);
        end
        return rom;
    endfunction

    localparam cs_rom_t CS_ROM = build_rom();

    typedef struct packed {
        logic [fgn_pkg::P_W-1:0]            pnx;
        logic [fgn_pkg::P_W-1:0]            pnz;
        logic [fgn_pkg::AMP_W-1:0]          ampn;
        logic [fgn_pkg::AMP_W-1:0]          amp;
        logic signed [fgn_pkg::TOT_W-1:0]   tot;
        logic [fgn_pkg::TAMP_W-1:0]         tamp;
        logic [fgn_pkg::U_W-1:0]            ux;
        logic [fgn_pkg::U_W-1:0]            uz;
    } car_t;

    logic [NST-1:1] vld_reg;

    // Stage 1
    logic [31:0]                       sk;
    logic [31:0]                       cx;
    logic [31:0]                       cz;
    logic [31:0]                       hcx0;
    logic [31:0]                       hcx1;
    logic [31:0]                       hcz0;
    logic [31:0]                       hcz1;
    logic [31:0]                       pre [4];
    logic [fgn_pkg::F_W-1:0]           fx;
    logic [fgn_pkg::F_W-1:0]           fz;
    logic signed [56:0]                mhx_full;
    logic signed [56:0]                mhz_full;
    logic [31:0]                       hp_reg [4];
    logic [31:0]                       ffx_reg;
    logic [31:0]                       ffz_reg;
    logic [17:0]                       wx_reg;
    logic [17:0]                       wz_reg;
    logic [fgn_pkg::F_W-1:0]           fx1_reg;
    logic [fgn_pkg::F_W-1:0]           fz1_reg;
    logic [47:0]                       mhx_reg;
    logic [47:0]                       mhz_reg;
    logic [55:0]                       mlx_reg;
    logic [55:0]                       mlz_reg;
    logic [56:0]                       ap_reg;
    logic [fgn_pkg::AMP_W-1:0]         amp1_reg;
    logic signed [fgn_pkg::TOT_W-1:0]  tot1_reg;
    logic [fgn_pkg::TAMP_W-1:0]        tamp1_reg;

    // Stage 2
    logic [31:0]                       m1 [4];
    logic [49:0]                       ufx;
    logic [49:0]                       ufz;
    logic [40:0]                       a41;
    car_t                              car2_next;
    logic [31:0]                       hq_reg [4];
    logic [fgn_pkg::F_W-1:0]           fx2_reg;
    logic [fgn_pkg::F_W-1:0]           fz2_reg;
    car_t                              car_reg [2:NST-1];

    // Stage 3
    logic [31:0]                       m2 [4];
    logic [31:0]                       h3_reg [4];
    logic [fgn_pkg::F_W-1:0]           fx3_reg;
    logic [fgn_pkg::F_W-1:0]           fz3_reg;

    // Stage 4
    logic signed [fgn_pkg::CS_W-1:0]   c4_next [4];
    logic signed [fgn_pkg::CS_W-1:0]   s4_next [4];
    logic signed [fgn_pkg::CS_W-1:0]   c4_reg [4];
    logic signed [fgn_pkg::CS_W-1:0]   s4_reg [4];
    logic signed [fgn_pkg::D_W-1:0]    dx0_reg;
    logic signed [fgn_pkg::D_W-1:0]    dx1_reg;
    logic signed [fgn_pkg::D_W-1:0]    dz0_reg;
    logic signed [fgn_pkg::D_W-1:0]    dz1_reg;

    // Stages 5 to 11
    logic signed [fgn_pkg::CS_W+fgn_pkg::D_W-1:0] cd5_reg [4];
    logic signed [fgn_pkg::CS_W+fgn_pkg::D_W-1:0] sd5_reg [4];
    logic signed [fgn_pkg::G_W-1:0]    g6_reg [4];
    logic signed [fgn_pkg::PR_W-1:0]   p70_reg;
    logic signed [fgn_pkg::PR_W-1:0]   p71_reg;
    logic signed [fgn_pkg::G_W-1:0]    g00_7_reg;
    logic signed [fgn_pkg::G_W-1:0]    g01_7_reg;
    logic signed [fgn_pkg::L_W-1:0]    l0_8_reg;
    logic signed [fgn_pkg::L_W-1:0]    l1_8_reg;
    logic signed [fgn_pkg::PR_W-1:0]   p9_reg;
    logic signed [fgn_pkg::L_W-1:0]    l0_9_reg;
    logic signed [fgn_pkg::L_W-1:0]    v10;
    logic signed [fgn_pkg::NZ_W-1:0]   nz10_reg;
    logic signed [fgn_pkg::AMP_W+fgn_pkg::NZ_W:0] an11_reg;

    // Stage 12
    logic                              out_v_reg;
    logic [fgn_pkg::P_W-1:0]           out_px_reg;
    logic [fgn_pkg::P_W-1:0]           out_pz_reg;
    logic [fgn_pkg::AMP_W-1:0]         out_amp_reg;
    logic signed [fgn_pkg::TOT_W-1:0]  out_tot_reg;
    logic [fgn_pkg::TAMP_W-1:0]        out_tamp_reg;

    always_comb
    begin
        sk   = seed + 32'(OCT_IDX);
        cx   = bus_in.px[63:32];
        cz   = bus_in.pz[63:32];
        fx   = bus_in.px[31:16];
        fz   = bus_in.pz[31:16];
        hcx0 = cx * fgn_pkg::HASH_CX;
        hcx1 = (cx + 32'd1) * fgn_pkg::HASH_CX;
        hcz0 = cz * fgn_pkg::HASH_CZ;
        hcz1 = (cz + 32'd1) * fgn_pkg::HASH_CZ;
        // Corner order: (x0,z0), (x1,z0), (x0,z1), (x1,z1).
        pre[0] = hcx0 ^ hcz0 ^ sk;
        pre[1] = hcx1 ^ hcz0 ^ sk;
        pre[2] = hcx0 ^ hcz1 ^ sk;
        pre[3] = hcx1 ^ hcz1 ^ sk;
        mhx_full = $signed(bus_in.px[63:32]) * $signed({1'b0, lac});
        mhz_full = $signed(bus_in.pz[63:32]) * $signed({1'b0, lac});
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            m1[j] = hp_reg[j] * fgn_pkg::MIX_A;
            m2[j] = hq_reg[j] * fgn_pkg::MIX_B;
        end
        ufx = 50'(ffx_reg) * 50'(wx_reg);
        ufz = 50'(ffz_reg) * 50'(wz_reg);
        a41 = ap_reg[56:16];
        car2_next.pnx  = {mhx_reg, 16'b0} + 64'(mlx_reg[55:16]);
        car2_next.pnz  = {mhz_reg, 16'b0} + 64'(mlz_reg[55:16]);
        car2_next.ampn = (a41 > 41'(fgn_pkg::AMP_CAP)) ? fgn_pkg::AMP_CAP : a41[36:0];
        car2_next.amp  = amp1_reg;
        car2_next.tot  = tot1_reg;
        car2_next.tamp = tamp1_reg;
        car2_next.ux   = ufx[48:32];
        car2_next.uz   = ufz[48:32];
    end

    // Gradient lookup: fold the quarter wave at its middle, then rotate by quadrant.
    always_comb
    begin
        logic [ANGLE_BITS-1:0]          idx;
        logic [1:0]                     q;
        logic [QB-1:0]                  r;
        logic [QB-1:0]                  m;
        logic                           fold;
        logic [31:0]                    ent;
        logic signed [fgn_pkg::CS_W-1:0] s0;
        logic signed [fgn_pkg::CS_W-1:0] c0;
        for (int j = 0; j < 4; j++)
        begin
            idx  = h3_reg[j][31 -: ANGLE_BITS];
            q    = idx[ANGLE_BITS-1 -: 2];
            r    = idx[QB-1:0];
            fold = (r > QB'(QN));
            m    = fold ? (QB'(0) - r) : r;
            ent  = CS_ROM[m];
            s0   = fold ? $signed({1'b0, ent[15:0]}) : $signed({1'b0, ent[31:16]});
            c0   = fold ? $signed({1'b0, ent[31:16]}) : $signed({1'b0, ent[15:0]});
            case (q)
                QUAD_0:
                begin
                    c4_next[j] = c0;
                    s4_next[j] = s0;
                end
                QUAD_1:
                begin
                    c4_next[j] = -s0;
                    s4_next[j] = c0;
                end
                QUAD_2:
                begin
                    c4_next[j] = -c0;
                    s4_next[j] = -s0;
                end
                default:
                begin
                    c4_next[j] = s0;
                    s4_next[j] = -c0;
                end
            endcase
        end
    end

    assign v10 = l0_9_reg + fgn_pkg::L_W'(p9_reg >>> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg   <= {vld_reg[NST-2:1], bus_in.v};
            out_v_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1: lattice hash products, smoothstep square, growth products.
            for (int j = 0; j < 4; j++)
            begin
                hp_reg[j] <= pre[j] ^ (pre[j] >> 16);
                hq_reg[j] <= m1[j] ^ (m1[j] >> 15);
                h3_reg[j] <= m2[j] ^ (m2[j] >> 16);
                c4_reg[j] <= c4_next[j];
                s4_reg[j] <= s4_next[j];
                g6_reg[j] <= fgn_pkg::G_W'(cd5_reg[j]) + fgn_pkg::G_W'(sd5_reg[j]);
            end
            ffx_reg   <= {16'b0, fx} * {16'b0, fx};
            ffz_reg   <= {16'b0, fz} * {16'b0, fz};
            wx_reg    <= 18'd196608 - {1'b0, fx, 1'b0};
            wz_reg    <= 18'd196608 - {1'b0, fz, 1'b0};
            fx1_reg   <= fx;
            fz1_reg   <= fz;
            mhx_reg   <= mhx_full[47:0];
            mhz_reg   <= mhz_full[47:0];
            mlx_reg   <= 56'(bus_in.px[31:0]) * 56'(lac);
            mlz_reg   <= 56'(bus_in.pz[31:0]) * 56'(lac);
            ap_reg    <= 57'(bus_in.amp) * 57'(gain);
            amp1_reg  <= bus_in.amp;
            tot1_reg  <= bus_in.tot;
            tamp1_reg <= bus_in.tamp;

            // Stage 2 and the carry line.
            fx2_reg    <= fx1_reg;
            fz2_reg    <= fz1_reg;
            car_reg[2] <= car2_next;
            for (int i = 3; i < NST; i++)
            begin
                car_reg[i] <= car_reg[i-1];
            end

            // Stage 3.
            fx3_reg <= fx2_reg;
            fz3_reg <= fz2_reg;

            // Stage 4: corner offsets in Q1.16.
            dx0_reg <= $signed({2'b0, fx3_reg});
            dx1_reg <= $signed({2'b0, fx3_reg}) - 18'sd65536;
            dz0_reg <= $signed({2'b0, fz3_reg});
            dz1_reg <= $signed({2'b0, fz3_reg}) - 18'sd65536;

            // Stage 5: products of gradient and offset, summed in stage 6.
            cd5_reg[0] <= c4_reg[0] * dx0_reg;
            sd5_reg[0] <= s4_reg[0] * dz0_reg;
            cd5_reg[1] <= c4_reg[1] * dx1_reg;
            sd5_reg[1] <= s4_reg[1] * dz0_reg;
            cd5_reg[2] <= c4_reg[2] * dx0_reg;
            sd5_reg[2] <= s4_reg[2] * dz1_reg;
            cd5_reg[3] <= c4_reg[3] * dx1_reg;
            sd5_reg[3] <= s4_reg[3] * dz1_reg;

            // Stage 7: blend along x, product part.
            p70_reg   <= (fgn_pkg::L_W'(g6_reg[1]) - fgn_pkg::L_W'(g6_reg[0]))
                         * $signed({1'b0, car_reg[6].ux});
            p71_reg   <= (fgn_pkg::L_W'(g6_reg[3]) - fgn_pkg::L_W'(g6_reg[2]))
                         * $signed({1'b0, car_reg[6].ux});
            g00_7_reg <= g6_reg[0];
            g01_7_reg <= g6_reg[2];

            // Stage 8: blend along x, sum part.
            l0_8_reg <= fgn_pkg::L_W'(g00_7_reg) + fgn_pkg::L_W'(p70_reg >>> 16);
            l1_8_reg <= fgn_pkg::L_W'(g01_7_reg) + fgn_pkg::L_W'(p71_reg >>> 16);

            // Stages 9 and 10: blend along z and scale to Q.16.
            p9_reg   <= (l1_8_reg - l0_8_reg) * $signed({1'b0, car_reg[8].uz});
            l0_9_reg <= l0_8_reg;
            nz10_reg <= fgn_pkg::NZ_W'(v10 >>> 15);

            // Stage 11: weight by this octave's amplitude.
            an11_reg <= $signed({1'b0, car_reg[10].amp}) * nz10_reg;

            // Stage 12: accumulate when this octave is in use.
            out_px_reg   <= car_reg[11].pnx;
            out_pz_reg   <= car_reg[11].pnz;
            out_amp_reg  <= car_reg[11].ampn;
            out_tot_reg  <= car_reg[11].tot
                            + (octave_on ? fgn_pkg::TOT_W'(an11_reg) : '0);
            out_tamp_reg <= car_reg[11].tamp
                            + (octave_on ? fgn_pkg::TAMP_W'(car_reg[11].amp) : '0);
        end
    end

    always_comb
    begin
        bus_out.v    = out_v_reg;
        bus_out.px   = out_px_reg;
        bus_out.pz   = out_pz_reg;
        bus_out.amp  = out_amp_reg;
        bus_out.tot  = out_tot_reg;
        bus_out.tamp = out_tamp_reg;
    end

endmodule

// ----- hw/rtl/fgn_div_cell.sv -----
// One restoring-division step as a registered cell of the normalization chain.
module fgn_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  fgn_pkg::div_bus_t bus_in,
    output fgn_pkg::div_bus_t bus_out
);

    logic [fgn_pkg::TAMP_W:0]   rem2;
    logic                       ge;
    logic                       v_reg;
    logic [fgn_pkg::TAMP_W-1:0] rem_reg;
    logic [fgn_pkg::TAMP_W-1:0] den_reg;
    logic [fgn_pkg::Q_W-1:0]    low_reg;
    logic [fgn_pkg::Q_W-1:0]    quo_reg;
    logic                       neg_reg;

    assign rem2 = {bus_in.rem, bus_in.low[fgn_pkg::Q_W-1]};
    assign ge   = (rem2 >= {1'b0, bus_in.den});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= bus_in.v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= fgn_pkg::TAMP_W'(ge ? (rem2 - {1'b0, bus_in.den}) : rem2);
            den_reg <= bus_in.den;
            low_reg <= {bus_in.low[fgn_pkg::Q_W-2:0], 1'b0};
            quo_reg <= {bus_in.quo[fgn_pkg::Q_W-2:0], ge};
            neg_reg <= bus_in.neg;
        end
    end

    always_comb
    begin
        bus_out.v   = v_reg;
        bus_out.rem = rem_reg;
        bus_out.den = den_reg;
        bus_out.low = low_reg;
        bus_out.quo = quo_reg;
        bus_out.neg = neg_reg;
    end

endmodule

// ----- hw/rtl/fbm_gradient_noise_2d.sv -----
// Top level of the fractal gradient noise terrain height pipeline.
//
//  Channel  Handshake                Payload
//  -------  -----------------------  --------------------------------------
//  cfg      cfg_valid / cfg_ready    cfg_index (3 bits), cfg_data (32 bits)
//  in       in_valid / in_stall      world_x, world_z (signed Q16.16)
//  out      out_valid / out_stall    height (signed Q1.15)
//
// One position enters per cycle while in_stall is low. The pipeline has one
// front stage, twelve stages per octave cell, one prep stage, one stage
// per quotient bit in the division chain, the scale stage and the output beat.
// Reset is asynchronous and active low; it clears valid bits and restores
// the register reset values. No clearing pass is needed after reset.
// When out_stall holds, one more result drains into a skid register and the
// whole pipeline then freezes, with in_stall raised from that register.
`include "fbm_gradient_noise_2d_macros.svh"

module fbm_gradient_noise_2d #(
    parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF,
    parameter int ANGLE_BITS  = fgn_pkg::ANGLE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [fgn_pkg::CFG_W-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [31:0]        world_x,
    input  logic signed [31:0]        world_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [15:0]        height
);

    // Configuration registers. The user must change them only while the pipeline
    // is empty; the block does not enforce this. Every stage reads them directly.
    logic [31:0] seed_reg;
    logic [3:0]  octs_reg;
    logic [31:0] bfreq_reg;
    logic [23:0] lac_reg;
    logic [19:0] gain_reg;
    logic [23:0] scale_reg;

    logic [4:0]             octs_eff;
    logic [MAX_OCTAVES-1:0] oct_on;

    // The whole datapath advances together; it stops only while the skid
    // register holds a beat.
    logic en;

    logic signed [64:0] mx;
    logic signed [64:0] mz;

    fgn_pkg::oct_bus_t oct_bus [MAX_OCTAVES+1];
    fgn_pkg::div_bus_t div_bus [fgn_pkg::Q_W+1];

    logic                         front_v_reg;
    logic [fgn_pkg::P_W-1:0]      front_px_reg;
    logic [fgn_pkg::P_W-1:0]      front_pz_reg;

    logic [fgn_pkg::TOT_W-1:0]    mag;
    logic                         prep_v_reg;
    logic [fgn_pkg::TAMP_W-1:0]   prep_rem_reg;
    logic [fgn_pkg::TAMP_W-1:0]   prep_den_reg;
    logic [fgn_pkg::Q_W-1:0]      prep_low_reg;
    logic                         prep_neg_reg;

    logic signed [fgn_pkg::Q_W:0]      norm;
    logic                              sp_v_reg;
    logic signed [fgn_pkg::Q_W+25:0]   sp_reg;
    logic signed [fgn_pkg::Q_W+8:0]    hs;
    logic signed [15:0]                hclamp;

    logic               out_valid_reg;
    logic signed [15:0] out_reg;
    logic               skid_valid_reg;
    logic signed [15:0] skid_reg;
    logic               out_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= fgn_pkg::SEED_RST;
            octs_reg  <= fgn_pkg::OCTS_RST;
            bfreq_reg <= fgn_pkg::BFREQ_RST;
            lac_reg   <= fgn_pkg::LAC_RST;
            gain_reg  <= fgn_pkg::GAIN_RST;
            scale_reg <= fgn_pkg::SCALE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fgn_pkg::REG_SEED:  seed_reg  <= cfg_data;
                fgn_pkg::REG_OCTS:  octs_reg  <= cfg_data[3:0];
                fgn_pkg::REG_BFREQ: bfreq_reg <= cfg_data;
                fgn_pkg::REG_LAC:   lac_reg   <= cfg_data[23:0];
                fgn_pkg::REG_GAIN:  gain_reg  <= cfg_data[19:0];
                fgn_pkg::REG_SCALE: scale_reg <= cfg_data[23:0];
                default:            ;
            endcase
        end
    end

    // A count of zero runs one octave; a count past the chain length runs all cells.
    always_comb
    begin
        if (octs_reg == 4'd0)
        begin
            octs_eff = 5'd1;
        end
        else if ({1'b0, octs_reg} > 5'(MAX_OCTAVES))
        begin
            octs_eff = 5'(MAX_OCTAVES);
        end
        else
        begin
            octs_eff = {1'b0, octs_reg};
        end
    end

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // Front stage: world position times base frequency gives the Q32.32 sample point.
    assign mx = world_x * $signed({1'b0, bfreq_reg});
    assign mz = world_z * $signed({1'b0, bfreq_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_v_reg <= 1'b0;
            prep_v_reg  <= 1'b0;
            sp_v_reg    <= 1'b0;
        end
        else if (en)
        begin
            front_v_reg <= in_valid;
            prep_v_reg  <= oct_bus[MAX_OCTAVES].v;
            sp_v_reg    <= div_bus[fgn_pkg::Q_W].v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_px_reg <= 64'(mx >>> 8);
            front_pz_reg <= 64'(mz >>> 8);
        end
    end

    always_comb
    begin
        oct_bus[0].v    = front_v_reg;
        oct_bus[0].px   = front_px_reg;
        oct_bus[0].pz   = front_pz_reg;
        oct_bus[0].amp  = fgn_pkg::AMP_ONE;
        oct_bus[0].tot  = '0;
        oct_bus[0].tamp = '0;
    end

    // The octave chain: cell k adds octave k if enabled and hands the grown position on.
    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_oct
        assign oct_on[k] = (octs_eff > 5'(k));

        fgn_octave_cell #(
            .ANGLE_BITS (ANGLE_BITS),
            .OCT_IDX    (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .octave_on (oct_on[k]),
            .seed      (seed_reg),
            .lac       (lac_reg),
            .gain      (gain_reg),
            .bus_in    (oct_bus[k]),
            .bus_out   (oct_bus[k+1])
        );
    end

    // Division prep. The quotient is a weighted mean of octave values, so its
    // magnitude stays below 2^Q_W and the top part of the dividend already
    // sits below the divisor.
    assign mag = oct_bus[MAX_OCTAVES].tot[fgn_pkg::TOT_W-1]
                 ? fgn_pkg::TOT_W'(-oct_bus[MAX_OCTAVES].tot)
                 : fgn_pkg::TOT_W'(oct_bus[MAX_OCTAVES].tot);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_rem_reg <= fgn_pkg::TAMP_W'(mag >> fgn_pkg::Q_W);
            prep_low_reg <= mag[fgn_pkg::Q_W-1:0];
            prep_den_reg <= oct_bus[MAX_OCTAVES].tamp;
            prep_neg_reg <= oct_bus[MAX_OCTAVES].tot[fgn_pkg::TOT_W-1];
        end
    end

    always_comb
    begin
        div_bus[0].v   = prep_v_reg;
        div_bus[0].rem = prep_rem_reg;
        div_bus[0].den = prep_den_reg;
        div_bus[0].low = prep_low_reg;
        div_bus[0].quo = '0;
        div_bus[0].neg = prep_neg_reg;
    end

    // The division chain: one quotient bit per cell, most significant first.
    for (genvar d = 0; d < fgn_pkg::Q_W; d++)
    begin : g_div
        fgn_div_cell u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .bus_in  (div_bus[d]),
            .bus_out (div_bus[d+1])
        );
    end

    // Quotient magnitude negated back gives truncation toward zero.
    assign norm = div_bus[fgn_pkg::Q_W].neg
                  ? -$signed({1'b0, div_bus[fgn_pkg::Q_W].quo})
                  : $signed({1'b0, div_bus[fgn_pkg::Q_W].quo});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg <= norm * $signed({1'b0, scale_reg});
        end
    end

    assign hs = (fgn_pkg::Q_W+9)'(sp_reg >>> 17);

    always_comb
    begin
        if (hs > 29'sd32767)
        begin
            hclamp = 16'sh7fff;
        end
        else if (hs < -29'sd32768)
        begin
            hclamp = -16'sh8000;
        end
        else
        begin
            hclamp = 16'(hs);
        end
    end

    // Output register with a one-beat skid behind it.
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (sp_v_reg)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (sp_v_reg)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= hclamp;
            end
            else
            begin
                out_reg <= hclamp;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign height    = out_reg;

    `FGN_ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid holds a beat while the output register is empty")
    `FGN_ASSERT_NEXT(a_no_skid_on_drain, clk, rst_n,
        out_valid_reg && !out_stall && !skid_valid_reg, !skid_valid_reg,
        "skid filled although the output beat was taken")
    `FGN_ASSERT_IMPLIES(a_div_rem_bound, clk, rst_n, div_bus[fgn_pkg::Q_W].v,
        div_bus[fgn_pkg::Q_W].rem < div_bus[fgn_pkg::Q_W].den,
        "division remainder not below the total amplitude")

endmodule
